// File: hdl/sparse_pattern_a_plus_at_core_assert.svh
// Assertion macros shared by the sparse pattern core.
`ifndef SPARSE_PATTERN_A_PLUS_AT_CORE_ASSERT_SVH
`define SPARSE_PATTERN_A_PLUS_AT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SPAAT_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("same-cycle check failed");
`define SPAAT_ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define SPAAT_ASSERT_IMP(lbl, clk, rst, a, b)
`define SPAAT_ASSERT_NXT(lbl, clk, rst, a, b)
`endif
`endif

// File: hdl/spaat_pkg.sv
// Shared types, constants and helpers of the sparse pattern core.
package spaat_pkg;
  localparam int MAX_DIM = 1024;
  localparam int MAX_NZ  = 8192;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = IDX_W + 1;
  localparam int NZA_W   = $clog2(MAX_NZ);
  localparam int NZ_W    = NZA_W + 1;
  localparam int TOT_W   = 15;
  localparam int MARK_W  = DIM_W;

  localparam logic [MARK_W-1:0] MARK_UNSEEN = '1;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [1:0] CFG_MATRIX_SIZE  = 2'd0;
  localparam logic [1:0] CFG_INCLUDE_DIAG = 2'd1;

  typedef enum logic [1:0] {CMD_CLEAR, CMD_LOAD, CMD_READ} cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic             in_range;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
  } cmd_t;

  typedef struct packed {
    logic             present;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic             final_flag;
    logic [TOT_W-1:0] total;
  } res_t;

  typedef struct packed {
    logic             built;
    logic [TOT_W-1:0] total;
  } back_stat_t;

  // Clamp the programmed size into 1..MAX_DIM.
  function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] size);
    logic [DIM_W-1:0] n;
    n = size;
    if (size == '0) n = DIM_W'(1);
    else if (size > DIM_W'(MAX_DIM)) n = DIM_W'(MAX_DIM);
    return n;
  endfunction
endpackage

// File: hdl/spaat_front.sv
// Front end: accept input items, classify them and queue commands.
module spaat_front import spaat_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [1:0]       mode,
  input  logic [IDX_W-1:0] entry_column,
  input  logic [IDX_W-1:0] entry_row,
  input  logic [DIM_W-1:0] matrix_size,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  logic             cmd_take
);
  cmd_t       q [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       enq;
  cmd_t       cls;
  logic [DIM_W-1:0] n;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_comb begin
    n = eff_size(matrix_size);
    cls.col = entry_column;
    cls.row = entry_row;
    cls.in_range = ({1'b0, entry_column} < n) && ({1'b0, entry_row} < n);
    enq = push && !full;
    case (mode)
      MODE_CLEAR: cls.op = CMD_CLEAR;
      MODE_LOAD:  cls.op = CMD_LOAD;
      MODE_READ:  cls.op = CMD_READ;
      default: begin
        cls.op = CMD_CLEAR;
        enq = 1'b0;  // drop the unused mode
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (enq) q[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) wr_ptr <= ~wr_ptr;
      if (cmd_take) rd_ptr <= ~rd_ptr;
      count <= count + 2'(enq) - 2'(cmd_take);
    end
  end
endmodule

// File: hdl/spaat_back.sv
// Back end: entry store, transpose build, count pass and emit sequencer.
module spaat_back import spaat_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_take,
  input  logic [DIM_W-1:0] matrix_size,
  input  logic             include_diagonal,
  output logic             res_push,
  output res_t             res,
  input  logic             res_full,
  output back_stat_t       stat
);
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SWEEP  = 9'b000000010,
    S_HIST   = 9'b000000100,
    S_PSUM   = 9'b000001000,
    S_SCAT   = 9'b000010000,
    S_COUNT  = 9'b000100000,
    S_SWEEP2 = 9'b001000000,
    S_EMIT   = 9'b010000000,
    S_RESULT = 9'b100000000
  } state_t;

  typedef enum logic [8:0] {
    E_COL = 9'b000000001,
    E_TS0 = 9'b000000010,
    E_TS1 = 9'b000000100,
    E_A   = 9'b000001000,
    E_A2  = 9'b000010000,
    E_A3  = 9'b000100000,
    E_T   = 9'b001000000,
    E_T2  = 9'b010000000,
    E_T3  = 9'b100000000
  } eng_step_t;

  state_t state, state_next;
  eng_step_t estep, estep_next;
  logic [1:0]       sub, sub_next;
  logic [NZ_W-1:0]  idx, idx_next;
  logic [NZ_W-1:0]  loaded, loaded_next;
  logic [IDX_W-1:0] last_col, last_col_next;
  logic [TOT_W-1:0] total, total_next;
  logic [TOT_W-1:0] cnt, cnt_next;
  logic [TOT_W-1:0] emitted, emitted_next;
  logic             built, built_next;
  logic [DIM_W-1:0] use_n, use_n_next;
  logic             use_diag, use_diag_next;
  logic [IDX_W-1:0] lat_col, lat_col_next;
  logic [IDX_W-1:0] lat_row, lat_row_next;
  logic [DIM_W-1:0] cur_col, cur_col_next;
  logic [NZ_W-1:0]  a_ptr, a_ptr_next;
  logic [NZ_W-1:0]  t_ptr, t_ptr_next;
  logic [NZ_W-1:0]  t_end, t_end_next;
  logic [NZ_W-1:0]  acc, acc_next;
  logic             rp, rp_next;
  logic [IDX_W-1:0] rcol, rcol_next;
  logic [IDX_W-1:0] rrow, rrow_next;

  logic eng_run, eng_found, eng_done;
  logic [IDX_W-1:0] f_col, f_row;

  // entry store: {column, row}
  logic [2*IDX_W-1:0] src_mem [0:MAX_NZ-1];
  logic               src_we, src_re;
  logic [NZA_W-1:0]   src_wa, src_ra;
  logic [2*IDX_W-1:0] src_wd, src_rd;
  logic [IDX_W-1:0]   s_col, s_row;

  // row counts, turned into transpose starts in place
  logic [NZ_W-1:0]  ts_mem [0:MAX_DIM];
  logic             ts_we, ts_re;
  logic [DIM_W-1:0] ts_wa, ts_ra;
  logic [NZ_W-1:0]  ts_wd, ts_rd;

  logic [NZ_W-1:0]  fill_mem [0:MAX_DIM-1];
  logic             fill_we, fill_re;
  logic [IDX_W-1:0] fill_wa, fill_ra;
  logic [NZ_W-1:0]  fill_wd, fill_rd;

  logic [IDX_W-1:0] tr_mem [0:MAX_NZ-1];
  logic             tr_we, tr_re;
  logic [NZA_W-1:0] tr_wa, tr_ra;
  logic [IDX_W-1:0] tr_wd, tr_rd;

  logic [MARK_W-1:0] mk_mem [0:MAX_DIM-1];
  logic              mk_we, mk_re;
  logic [IDX_W-1:0]  mk_wa, mk_ra;
  logic [MARK_W-1:0] mk_wd, mk_rd;

  assign s_col = src_rd[2*IDX_W-1:IDX_W];
  assign s_row = src_rd[IDX_W-1:0];
  assign eng_run = (state == S_COUNT) || (state == S_EMIT);

  always_comb begin
    state_next    = state;
    estep_next    = estep;
    sub_next      = sub;
    idx_next      = idx;
    loaded_next   = loaded;
    last_col_next = last_col;
    total_next    = total;
    cnt_next      = cnt;
    emitted_next  = emitted;
    built_next    = built;
    use_n_next    = use_n;
    use_diag_next = use_diag;
    lat_col_next  = lat_col;
    lat_row_next  = lat_row;
    cur_col_next  = cur_col;
    a_ptr_next    = a_ptr;
    t_ptr_next    = t_ptr;
    t_end_next    = t_end;
    acc_next      = acc;
    rp_next       = rp;
    rcol_next     = rcol;
    rrow_next     = rrow;
    cmd_take      = 1'b0;
    res_push      = 1'b0;
    eng_found     = 1'b0;
    eng_done      = 1'b0;
    f_col         = '0;
    f_row         = '0;
    src_we = 1'b0; src_wa = '0; src_wd = '0; src_re = 1'b0; src_ra = '0;
    ts_we = 1'b0; ts_wa = '0; ts_wd = '0; ts_re = 1'b0; ts_ra = '0;
    fill_we = 1'b0; fill_wa = '0; fill_wd = '0; fill_re = 1'b0; fill_ra = '0;
    tr_we = 1'b0; tr_wa = '0; tr_wd = '0; tr_re = 1'b0; tr_ra = '0;
    mk_we = 1'b0; mk_wa = '0; mk_wd = '0; mk_re = 1'b0; mk_ra = '0;

    // candidate walker: column by column, rows of A then rows of A'
    if (eng_run) begin
      case (estep)
        E_COL: begin
          if (cur_col >= use_n) begin
            eng_done = 1'b1;
          end else begin
            mk_we = 1'b1;
            mk_wa = cur_col[IDX_W-1:0];
            mk_wd = cur_col;
            ts_re = 1'b1;
            ts_ra = cur_col;
            if (use_diag) begin
              eng_found = 1'b1;
              f_col = cur_col[IDX_W-1:0];
              f_row = cur_col[IDX_W-1:0];
            end
            estep_next = E_TS0;
          end
        end
        E_TS0: begin
          t_ptr_next = ts_rd;
          ts_re = 1'b1;
          ts_ra = cur_col + DIM_W'(1);
          estep_next = E_TS1;
        end
        E_TS1: begin
          t_end_next = ts_rd;
          estep_next = E_A;
        end
        E_A: begin
          if (a_ptr < loaded) begin
            src_re = 1'b1;
            src_ra = a_ptr[NZA_W-1:0];
            estep_next = E_A2;
          end else begin
            estep_next = E_T;
          end
        end
        E_A2: begin
          if ({1'b0, s_col} == cur_col) begin
            mk_re = 1'b1;
            mk_ra = s_row;
            estep_next = E_A3;
          end else begin
            estep_next = E_T;
          end
        end
        E_A3: begin
          a_ptr_next = a_ptr + NZ_W'(1);
          if (({1'b0, s_row} < use_n) && (mk_rd != cur_col)) begin
            mk_we = 1'b1;
            mk_wa = s_row;
            mk_wd = cur_col;
            eng_found = 1'b1;
            f_col = cur_col[IDX_W-1:0];
            f_row = s_row;
          end
          estep_next = E_A;
        end
        E_T: begin
          if (t_ptr < t_end) begin
            tr_re = 1'b1;
            tr_ra = t_ptr[NZA_W-1:0];
            estep_next = E_T2;
          end else begin
            cur_col_next = cur_col + DIM_W'(1);
            estep_next = E_COL;
          end
        end
        E_T2: begin
          mk_re = 1'b1;
          mk_ra = tr_rd;
          estep_next = E_T3;
        end
        E_T3: begin
          t_ptr_next = t_ptr + NZ_W'(1);
          if (({1'b0, tr_rd} < use_n) && (mk_rd != cur_col)) begin
            mk_we = 1'b1;
            mk_wa = tr_rd;
            mk_wd = cur_col;
            eng_found = 1'b1;
            f_col = cur_col[IDX_W-1:0];
            f_row = tr_rd;
          end
          estep_next = E_T;
        end
        default: estep_next = E_COL;
      endcase
    end

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            CMD_CLEAR: begin
              cmd_take      = 1'b1;
              loaded_next   = '0;
              last_col_next = '0;
              total_next    = '0;
              built_next    = 1'b0;
            end
            CMD_LOAD: begin
              cmd_take   = 1'b1;
              built_next = 1'b0;
              if (cmd.in_range && (loaded != NZ_W'(MAX_NZ)) &&
                  !((loaded != '0) && (cmd.col < last_col))) begin
                src_we        = 1'b1;
                src_wa        = loaded[NZA_W-1:0];
                src_wd        = {cmd.col, cmd.row};
                loaded_next   = loaded + NZ_W'(1);
                last_col_next = cmd.col;
              end
            end
            CMD_READ: begin
              if (built) begin
                state_next = S_EMIT;
              end else begin
                use_n_next    = eff_size(matrix_size);
                use_diag_next = include_diagonal;
                idx_next      = '0;
                state_next    = S_SWEEP;
              end
            end
            default: cmd_take = 1'b1;
          endcase
        end
      end
      S_SWEEP: begin
        ts_we = 1'b1;
        ts_wa = idx[DIM_W-1:0];
        ts_wd = '0;
        if (idx < NZ_W'(MAX_DIM)) begin
          mk_we = 1'b1;
          mk_wa = idx[IDX_W-1:0];
          mk_wd = MARK_UNSEEN;
        end
        if (idx == NZ_W'(MAX_DIM)) begin
          idx_next   = '0;
          sub_next   = 2'd0;
          state_next = S_HIST;
        end else begin
          idx_next = idx + NZ_W'(1);
        end
      end
      S_HIST: begin
        case (sub)
          2'd0: begin
            if (idx < loaded) begin
              src_re   = 1'b1;
              src_ra   = idx[NZA_W-1:0];
              sub_next = 2'd1;
            end else begin
              idx_next   = '0;
              acc_next   = '0;
              state_next = S_PSUM;
            end
          end
          2'd1: begin
            if (({1'b0, s_col} < use_n) && ({1'b0, s_row} < use_n)) begin
              ts_re        = 1'b1;
              ts_ra        = {1'b0, s_row} + DIM_W'(1);
              lat_row_next = s_row;
              sub_next     = 2'd2;
            end else begin
              idx_next = idx + NZ_W'(1);
              sub_next = 2'd0;
            end
          end
          default: begin
            ts_we    = 1'b1;
            ts_wa    = {1'b0, lat_row} + DIM_W'(1);
            ts_wd    = ts_rd + NZ_W'(1);
            idx_next = idx + NZ_W'(1);
            sub_next = 2'd0;
          end
        endcase
      end
      S_PSUM: begin
        if (sub == 2'd0) begin
          ts_re    = 1'b1;
          ts_ra    = idx[DIM_W-1:0];
          sub_next = 2'd1;
        end else begin
          acc_next = acc + ts_rd;
          ts_we    = 1'b1;
          ts_wa    = idx[DIM_W-1:0];
          ts_wd    = acc_next;
          if (idx[DIM_W-1:0] < use_n) begin
            fill_we = 1'b1;
            fill_wa = idx[IDX_W-1:0];
            fill_wd = acc_next;
          end
          sub_next = 2'd0;
          if (idx[DIM_W-1:0] == use_n) begin
            idx_next   = '0;
            state_next = S_SCAT;
          end else begin
            idx_next = idx + NZ_W'(1);
          end
        end
      end
      S_SCAT: begin
        case (sub)
          2'd0: begin
            if (idx < loaded) begin
              src_re   = 1'b1;
              src_ra   = idx[NZA_W-1:0];
              sub_next = 2'd1;
            end else begin
              cur_col_next = '0;
              a_ptr_next   = '0;
              estep_next   = E_COL;
              cnt_next     = '0;
              state_next   = S_COUNT;
            end
          end
          2'd1: begin
            if (({1'b0, s_col} < use_n) && ({1'b0, s_row} < use_n)) begin
              fill_re      = 1'b1;
              fill_ra      = s_row;
              lat_col_next = s_col;
              lat_row_next = s_row;
              sub_next     = 2'd2;
            end else begin
              idx_next = idx + NZ_W'(1);
              sub_next = 2'd0;
            end
          end
          default: begin
            tr_we    = 1'b1;
            tr_wa    = fill_rd[NZA_W-1:0];
            tr_wd    = lat_col;
            fill_we  = 1'b1;
            fill_wa  = lat_row;
            fill_wd  = fill_rd + NZ_W'(1);
            idx_next = idx + NZ_W'(1);
            sub_next = 2'd0;
          end
        endcase
      end
      S_COUNT: begin
        if (eng_found) cnt_next = cnt + TOT_W'(1);
        if (eng_done) begin
          total_next = cnt;
          idx_next   = '0;
          state_next = S_SWEEP2;
        end
      end
      S_SWEEP2: begin
        mk_we = 1'b1;
        mk_wa = idx[IDX_W-1:0];
        mk_wd = MARK_UNSEEN;
        if (idx == NZ_W'(MAX_DIM - 1)) begin
          cur_col_next = '0;
          a_ptr_next   = '0;
          estep_next   = E_COL;
          emitted_next = '0;
          built_next   = 1'b1;
          state_next   = S_EMIT;
        end else begin
          idx_next = idx + NZ_W'(1);
        end
      end
      S_EMIT: begin
        if (eng_found) begin
          rp_next      = 1'b1;
          rcol_next    = f_col;
          rrow_next    = f_row;
          emitted_next = emitted + TOT_W'(1);
          state_next   = S_RESULT;
        end else if (eng_done) begin
          rp_next    = 1'b0;
          rcol_next  = '0;
          rrow_next  = '0;
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          cmd_take   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    res.present    = rp;
    res.col        = rcol;
    res.row        = rrow;
    res.final_flag = !rp || (emitted >= total);
    res.total      = total;
    stat.built     = built;
    stat.total     = total;
  end

  always_ff @(posedge clk) begin
    if (src_we) src_mem[src_wa] <= src_wd;
    if (src_re) src_rd <= src_mem[src_ra];
  end

  always_ff @(posedge clk) begin
    if (ts_we) ts_mem[ts_wa] <= ts_wd;
    if (ts_re) ts_rd <= ts_mem[ts_ra];
  end

  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
    if (fill_re) fill_rd <= fill_mem[fill_ra];
  end

  always_ff @(posedge clk) begin
    if (tr_we) tr_mem[tr_wa] <= tr_wd;
    if (tr_re) tr_rd <= tr_mem[tr_ra];
  end

  always_ff @(posedge clk) begin
    if (mk_we) mk_mem[mk_wa] <= mk_wd;
    if (mk_re) mk_rd <= mk_mem[mk_ra];
  end

  always_ff @(posedge clk) begin
    sub     <= sub_next;
    idx     <= idx_next;
    cnt     <= cnt_next;
    use_n   <= use_n_next;
    use_diag <= use_diag_next;
    lat_col <= lat_col_next;
    lat_row <= lat_row_next;
    cur_col <= cur_col_next;
    a_ptr   <= a_ptr_next;
    t_ptr   <= t_ptr_next;
    t_end   <= t_end_next;
    acc     <= acc_next;
    rp      <= rp_next;
    rcol    <= rcol_next;
    rrow    <= rrow_next;
    emitted <= emitted_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      estep    <= E_COL;
      loaded   <= '0;
      last_col <= '0;
      total    <= '0;
      built    <= 1'b0;
    end else begin
      state    <= state_next;
      estep    <= estep_next;
      loaded   <= loaded_next;
      last_col <= last_col_next;
      total    <= total_next;
      built    <= built_next;
    end
  end
endmodule

// File: hdl/spaat_outq.sv
// Result queue between the back end and the result ports.
module spaat_outq import spaat_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic res_push,
  input  res_t res_in,
  output logic res_full,
  output logic empty,
  input  logic pop,
  output res_t res_out
);
  res_t       q [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       deq;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign res_out  = q[rd_ptr];
  assign deq      = pop && !empty;

  always_ff @(posedge clk) begin
    if (res_push) q[wr_ptr] <= res_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res_push) wr_ptr <= ~wr_ptr;
      if (deq) rd_ptr <= ~rd_ptr;
      count <= count + 2'(res_push) - 2'(deq);
    end
  end
endmodule

// File: hdl/sparse_pattern_a_plus_at_core.sv
// Top level of the symmetric A plus A-transpose pattern core.
//
// Feed the nonzero pattern of a square sparse matrix A as (column,row)
// loads in nondecreasing column order, then issue reads: each read returns
// the next entry of the pattern of A + A', column by column, each row once,
// diagonal dropped or (include_diagonal = 1) emitted first in its column,
// together with the total entry count. A clear or a load throws away the
// built pattern; the next read rebuilds it. Items go into a two-entry
// command queue; results leave through a two-entry result queue. A waiting
// result holds the back end only once the result queue is full, and full
// rises once the command queue has filled behind it. The first read after a
// clear or load runs the build: a sweep over the row-count and marker
// memories, a row count over the loaded entries, a prefix sum, a scatter
// of the transpose, one full walk of the pattern to count it, and a
// marker sweep. After that each read walks on from where the last one
// stopped, candidate row by candidate row (A then A'); each column crossed
// fetches the transpose bounds, finds the end of the column in A and
// closes A'. Each candidate row takes a read of the marker memory and,
// for a new row, a write of it.
// Configuration writes are always taken (cfg_ready is high); write them
// only while the core is idle. matrix_size is clamped into 1..1024.
module sparse_pattern_a_plus_at_core import spaat_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [1:0]       mode,
  input  logic [IDX_W-1:0] entry_column,
  input  logic [IDX_W-1:0] entry_row,
  output logic             empty,
  input  logic             pop,
  output logic             entry_present,
  output logic [IDX_W-1:0] out_column,
  output logic [IDX_W-1:0] out_row,
  output logic             final_entry,
  output logic [TOT_W-1:0] total_entries,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);
`include "sparse_pattern_a_plus_at_core_assert.svh"

  logic [DIM_W-1:0] matrix_size;
  logic             include_diagonal;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_take;
  logic             res_push;
  res_t             res;
  logic             res_full;
  res_t             res_out;
  back_stat_t       stat;

  // Settings are taken on every transfer; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size      <= DIM_W'(MAX_DIM);
      include_diagonal <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MATRIX_SIZE:  matrix_size <= cfg_data;
        CFG_INCLUDE_DIAG: include_diagonal <= cfg_data[0];
        default: ;
      endcase
    end
  end

  spaat_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .mode         (mode),
    .entry_column (entry_column),
    .entry_row    (entry_row),
    .matrix_size  (matrix_size),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take)
  );

  spaat_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_take         (cmd_take),
    .matrix_size      (matrix_size),
    .include_diagonal (include_diagonal),
    .res_push         (res_push),
    .res              (res),
    .res_full         (res_full),
    .stat             (stat)
  );

  spaat_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .res_out  (res_out)
  );

  // Present the head of the result queue.
  assign entry_present = res_out.present;
  assign out_column    = res_out.col;
  assign out_row       = res_out.row;
  assign final_entry   = res_out.final_flag;
  assign total_entries = res_out.total;

  `SPAAT_ASSERT_IMP(a_push_room, clk, rst, res_push, !res_full)
  `SPAAT_ASSERT_IMP(a_take_valid, clk, rst, cmd_take, cmd_valid)
  `SPAAT_ASSERT_IMP(a_entry_counted, clk, rst, res_push && res.present, stat.total != '0)
  `SPAAT_ASSERT_NXT(a_clear_unbuilds, clk, rst, cmd_take && cmd.op == CMD_CLEAR, !stat.built)
endmodule
